// ===== hw/rtl/haue_pkg.sv =====
// Package for the HTML anchor link extractor.
// Holds the recognizer state encoding, character codes and the result struct.
// No dependencies.
package haue_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned USER_W = 3;

    // Character codes the recognizer matches on
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_A     = 8'h61;
    localparam logic [BYTE_W-1:0] CH_E     = 8'h65;
    localparam logic [BYTE_W-1:0] CH_F     = 8'h66;
    localparam logic [BYTE_W-1:0] CH_H     = 8'h68;
    localparam logic [BYTE_W-1:0] CH_R     = 8'h72;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_LT     = 11'b000_0000_0010,
        ST_A      = 11'b000_0000_0100,
        ST_ATTR   = 11'b000_0000_1000,
        ST_H      = 11'b000_0001_0000,
        ST_HR     = 11'b000_0010_0000,
        ST_HRE    = 11'b000_0100_0000,
        ST_HREF   = 11'b000_1000_0000,
        ST_EQ     = 11'b001_0000_0000,
        ST_VALUE  = 11'b010_0000_0000,
        ST_CLOSED = 11'b100_0000_0000
    } t_parse_state;

    typedef struct packed {
        logic              url_dropped;
        logic              url_done;
        logic              byte_valid;
        logic [BYTE_W-1:0] url_byte;
    } t_result;

    function automatic logic is_white(input logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    // Fallback inside the attribute run after a partial "href" match
    function automatic t_parse_state attr_fallback(input logic [BYTE_W-1:0] c);
        if (c == CH_H) begin
            return ST_H;
        end else if (c == CH_GT) begin
            return ST_IDLE;
        end
        return ST_ATTR;
    endfunction

endpackage

// ===== hw/rtl/html_anchor_url_extractor_top.sv =====
// HTML anchor link extractor, top level.
// Depends on haue_pkg, haue_parse and haue_obuf.
//
// Takes one document byte per cycle while s_axis_tready is high and streams
// out the bytes of each <a ... href="..."> value up to its first space, CR or
// LF, then a done marker at the closing '>', or a dropped marker if the document
// ends (tlast or a zero byte) while a value is pending. A byte is parsed in the
// cycle it is accepted and its result, if any, is registered into the output
// buffer. The recognizer state and truncation registers are the only feedback
// loop in the parser, so the block sustains one byte per cycle while ready is
// high; the two-entry output buffer keeps s_axis_tready high until an output stall leaves a result in its skid stage.
module html_anchor_url_extractor_top
    import haue_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
    input  logic              s_axis_tlast,   // document_end
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] url_byte
    output logic [USER_W-1:0] m_axis_tuser    // [0] byte_valid, [1] url_done, [2] url_dropped
);

    logic    in_xfer;
    logic    has_result;
    t_result result;
    t_result out_data;

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    haue_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_xfer),
        .i_byte       (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .o_has_result (has_result),
        .o_result     (result)
    );

    haue_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer && has_result),
        .i_data  (result),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_take  (m_axis_tready),
        .o_data  (out_data)
    );

    assign m_axis_tdata = out_data.url_byte;
    assign m_axis_tuser = {out_data.url_dropped, out_data.url_done, out_data.byte_valid};

endmodule

// ===== hw/rtl/haue_parse.sv =====
// Byte recognizer: state register plus next-state and result logic.
// Depends on haue_pkg.
module haue_parse
    import haue_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    output logic              o_has_result,
    output t_result           o_result
);

    t_parse_state r_state, n_state;
    logic         r_trunc, n_trunc;
    t_parse_state s;
    logic         doc_end;

    always_comb begin
        s             = r_state;
        n_trunc       = r_trunc;
        o_result      = '0;
        doc_end       = i_last || (i_byte == CH_NUL);

        if (i_byte != CH_NUL) begin
            unique case (r_state)
                ST_LT: begin
                    if (i_byte == CH_A) begin
                        s = ST_A;
                    end else if (is_white(i_byte)) begin
                        s = ST_LT;
                    end else begin
                        s = ST_IDLE;
                    end
                end
                ST_A: s = is_white(i_byte) ? ST_ATTR : ST_IDLE;
                ST_ATTR: s = attr_fallback(i_byte);
                ST_H: s = (i_byte == CH_R) ? ST_HR : attr_fallback(i_byte);
                ST_HR: s = (i_byte == CH_E) ? ST_HRE : attr_fallback(i_byte);
                ST_HRE: s = (i_byte == CH_F) ? ST_HREF : attr_fallback(i_byte);
                ST_HREF: begin
                    if (i_byte == CH_EQ) begin
                        s = ST_EQ;
                    end else if (is_white(i_byte)) begin
                        s = ST_HREF;
                    end else begin
                        s = attr_fallback(i_byte);
                    end
                end
                ST_EQ: begin
                    if (i_byte == CH_QUOTE) begin
                        s       = ST_VALUE;
                        n_trunc = 1'b0;
                    end else if (is_white(i_byte)) begin
                        s = ST_EQ;
                    end else begin
                        s = attr_fallback(i_byte);
                    end
                end
                ST_VALUE: begin
                    if (i_byte == CH_QUOTE) begin
                        s = ST_CLOSED;
                    end else if ((i_byte == CH_SPACE) || (i_byte == CH_CR)
                                 || (i_byte == CH_LF)) begin
                        n_trunc = 1'b1;
                    end else if (!r_trunc) begin
                        o_result.url_byte   = i_byte;
                        o_result.byte_valid = 1'b1;
                    end
                end
                ST_CLOSED: begin
                    if (i_byte == CH_GT) begin
                        s                 = ST_IDLE;
                        o_result.url_done = 1'b1;
                        n_trunc           = 1'b0;
                    end
                end
                // idle and any corrupt code
                default: s = (i_byte == CH_LT) ? ST_LT : ST_IDLE;
            endcase
        end

        if (doc_end) begin
            o_result.url_dropped = (s == ST_VALUE) || (s == ST_CLOSED);
            s                    = ST_IDLE;
            n_trunc              = 1'b0;
        end
        n_state      = s;
        o_has_result = o_result.byte_valid || o_result.url_done || o_result.url_dropped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_trunc <= 1'b0;
        end else if (i_accept) begin
            r_state <= n_state;
            r_trunc <= n_trunc;
        end
    end

endmodule

// ===== hw/rtl/haue_obuf.sv =====
// Output register with skid stage; keeps input ready while one result waits in the output register.
// Depends on haue_pkg.
module haue_obuf
    import haue_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_take,
    output t_result o_data
);

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main, n_main;
    t_result r_skid, n_skid;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (!r_main_valid || i_take) begin
            if (r_skid_valid) begin
                // push is blocked while the skid stage is full
                n_main_valid = 1'b1;
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_main_valid = i_push;
                n_main       = i_data;
            end
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid       = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

endmodule

// ===== hw/rtl/haue_checker.sv =====
// Port-level checks for the anchor link extractor, bound to the top level.
// Depends on haue_pkg and html_anchor_url_extractor_top.
module haue_checker
    import haue_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [BYTE_W-1:0] m_axis_tdata,
    input logic [USER_W-1:0] m_axis_tuser
);

    // A stalled result transfer holds its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // Every result carries at least one flag
    a_flag_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser != '0))
        else $error("result without flags");

    // No link byte means a zero data byte
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata == '0))
        else $error("data byte set without byte_valid");

    // Done comes only from the closed state on '>': never with a byte or drop
    a_done_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0] && !m_axis_tuser[2])
        else $error("done marker combined with other flags");

    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind html_anchor_url_extractor_top haue_checker u_haue_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
